/* design/ffra_pkg.sv */
package ffra_pkg;

  localparam int FREE_ENTRIES = 16;
  localparam int USED_ENTRIES = 16;
  localparam int ADDR_BITS = 40;
  localparam int FIDX_BITS = $clog2(FREE_ENTRIES);
  localparam int UIDX_BITS = $clog2(USED_ENTRIES);
  localparam int FCNT_BITS = $clog2(FREE_ENTRIES + 1);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_NOTALLOC = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef struct packed {
    logic req_type;
    logic [39:0] req_offset;
    logic [39:0] req_size;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [39:0] alloc_offset;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request, clear scan index
    logic scan_step;   // advance scan index
    logic uscan_step;  // advance used scan index
    logic alloc_apply; // trim or remove hit entry, record used entry
    logic merge_prev;  // extend entry f by freed range
    logic merge_next;  // extend entry f downward
    logic merge_fold;  // fold entry f+1 into f
    logic ins_open;    // begin insert at f
    logic shift_step;  // one shift step of insert/remove
    logic release_used;
    logic set_rsp;
    logic [1:0] rsp_status;
  } ffra_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;    // scan index reached free_count
    logic alloc_fit;   // entry at scan index fits request
    logic free_after;  // entry end >= offset
    logic used_end;    // used scan index at last entry
    logic used_hit;    // used entry at used index matches (free) or is empty (alloc)
    logic adj_prev;    // end of entry f == offset
    logic adj_next;    // start of entry f == offset+size
    logic fold_ok;     // after merge_prev, entry f+1 abuts
    logic free_full;
    logic exact;       // hit length == size
    logic shift_done;
  } ffra_sts_t;

endpackage

/* design/first_fit_range_allocator_top.sv */
// First-fit range allocator over [0, pool_size). Each request is handled alone:
// it scans the 16-entry free table and the 16-entry used table one entry per
// cycle and then shifts free entries one per cycle on a remove or insert, so one
// request's table walks finish before the next request is accepted. Writing
// pool_size reloads the tables and drops any request in flight, so write it only while
// idle. A result is held until taken, then the next request is accepted.
module first_fit_range_allocator_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [39:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  ffra_pkg::req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output ffra_pkg::rsp_t out_data
);
  ffra_pkg::ffra_cmd_t cmd;
  ffra_pkg::ffra_sts_t sts;

  ffra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .req_type(in_data.req_type), .sts(sts), .cmd(cmd)
  );

  ffra_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we),
    .cfg_data(cfg_data[ffra_pkg::ADDR_BITS-1:0]),
    .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request accepted with result pending");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst || cfg_we)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ffra_pkg::ST_OK) |-> out_data.alloc_offset == '0)
    else $error("offset nonzero on failure");
`endif
endmodule

/* design/ffra_datapath.sv */
module ffra_datapath (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ffra_pkg::ADDR_BITS-1:0] cfg_data,
  input  ffra_pkg::req_t req,
  input  ffra_pkg::ffra_cmd_t cmd,
  output ffra_pkg::ffra_sts_t sts,
  output ffra_pkg::rsp_t rsp
);
  localparam int AB = ffra_pkg::ADDR_BITS;
  localparam int FB = ffra_pkg::FIDX_BITS;
  localparam int UB = ffra_pkg::UIDX_BITS;
  localparam int CB = ffra_pkg::FCNT_BITS;
  localparam int NF = ffra_pkg::FREE_ENTRIES;
  localparam int NU = ffra_pkg::USED_ENTRIES;

  logic [AB-1:0] free_start [NF];
  logic [AB-1:0] free_length [NF];
  logic [CB-1:0] free_count;
  logic [AB-1:0] used_start [NU];
  logic [AB-1:0] used_length [NU];
  logic [NU-1:0] used_valid;

  logic req_kind;
  logic [AB-1:0] off, size;
  logic [CB-1:0] idx;     // scan index / shift position
  logic [CB-1:0] shift_lim;
  logic shift_rm;          // remove (left shift) vs insert (right shift)
  logic [UB-1:0] uidx;

  logic [FB-1:0] fi, fi1, si;
  logic [UB-1:0] ui;
  logic [AB:0] f_end;

  assign fi = idx[FB-1:0];
  assign fi1 = fi + FB'(1);
  assign si = idx[FB-1:0];
  assign ui = uidx;
  // range end kept one bit wider so a sum past the top never aliases
  assign f_end = {1'b0, free_start[fi]} + {1'b0, free_length[fi]};

  always_comb begin
    sts = '0;
    sts.scan_end = (idx >= free_count);
    sts.alloc_fit = (free_length[fi] >= size);
    sts.free_after = (f_end >= {1'b0, off});
    sts.used_end = (uidx == UB'(NU - 1));
    sts.used_hit = (req_kind == ffra_pkg::REQ_ALLOC) ? !used_valid[ui]
                 : (used_valid[ui] && used_start[ui] == off && used_length[ui] == size);
    sts.adj_prev = (f_end == {1'b0, off});
    sts.adj_next = ({1'b0, free_start[fi]} == ({1'b0, off} + {1'b0, size}));
    sts.fold_ok = (CB'(fi) + CB'(1) < free_count) && (CB'(fi) + CB'(1) < CB'(NF)) &&
                  (f_end == {1'b0, free_start[fi1]});
    sts.free_full = (free_count >= CB'(NF));
    sts.exact = (free_length[fi] == size);
    sts.shift_done = shift_rm ? (idx + CB'(1) >= shift_lim) : (idx <= shift_lim);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      free_count <= CB'(1);
      used_valid <= '0;
      free_start[0] <= '0;
      free_length[0] <= rst ? '0 : cfg_data;
      idx <= '0;
      uidx <= '0;
      shift_rm <= 1'b0;
    end else begin
      if (cmd.load) begin
        req_kind <= req.req_type;
        off <= req.req_offset;
        size <= req.req_size;
        idx <= '0;
        uidx <= '0;
      end
      if (cmd.scan_step) idx <= idx + CB'(1);
      if (cmd.uscan_step) uidx <= uidx + UB'(1);
      if (cmd.alloc_apply) begin
        used_start[ui] <= free_start[fi];
        used_length[ui] <= size;
        used_valid[ui] <= 1'b1;
        if (free_length[fi] == size) begin
          // remove: shift left from idx
          shift_rm <= 1'b1;
          shift_lim <= free_count;
          free_count <= free_count - CB'(1);
        end else begin
          free_start[fi] <= free_start[fi] + size;
          free_length[fi] <= free_length[fi] - size;
        end
      end
      if (cmd.release_used) used_valid[ui] <= 1'b0;
      if (cmd.merge_prev) free_length[fi] <= free_length[fi] + size;
      if (cmd.merge_next) begin
        free_start[fi] <= free_start[fi] - size;
        free_length[fi] <= free_length[fi] + size;
      end
      if (cmd.merge_fold) begin
        free_length[fi] <= free_length[fi] + free_length[fi1];
        idx <= idx + CB'(1);
        shift_rm <= 1'b1;
        shift_lim <= free_count;
        free_count <= free_count - CB'(1);
      end
      if (cmd.ins_open) begin
        // insert at idx: shift right from free_count down
        shift_rm <= 1'b0;
        shift_lim <= idx;
        idx <= free_count;
        free_count <= free_count + CB'(1);
      end
      if (cmd.shift_step) begin
        if (shift_rm) begin
          if (idx + CB'(1) < shift_lim) begin
            free_start[si] <= free_start[si + FB'(1)];
            free_length[si] <= free_length[si + FB'(1)];
          end
          idx <= idx + CB'(1);
        end else if (idx > shift_lim) begin
          free_start[si] <= free_start[si - FB'(1)];
          free_length[si] <= free_length[si - FB'(1)];
          idx <= idx - CB'(1);
        end else begin
          free_start[si] <= off;
          free_length[si] <= size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp <= '0;
    end else if (cmd.set_rsp) begin
      rsp.status <= cmd.rsp_status;
      rsp.alloc_offset <= (req_kind == ffra_pkg::REQ_ALLOC && cmd.rsp_status == ffra_pkg::ST_OK)
                          ? used_start[ui] : '0;
    end
  end
endmodule

/* design/ffra_ctrl.sv */
module ffra_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic req_type,
  input  ffra_pkg::ffra_sts_t sts,
  output ffra_pkg::ffra_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FSCAN = 4'd1;
  localparam logic [3:0] S_USCAN = 4'd2;
  localparam logic [3:0] S_AAPPLY = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_RSCAN = 4'd5;
  localparam logic [3:0] S_FFIND = 4'd6;
  localparam logic [3:0] S_FDECIDE = 4'd7;
  localparam logic [3:0] S_FOLD = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] st_hold, st_hold_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_IDLE;
      st_hold <= ffra_pkg::ST_OK;
    end else begin
      state <= state_next;
      st_hold <= st_hold_next;
    end
  end

  always_comb begin
    state_next = state;
    st_hold_next = st_hold;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = (req_type == ffra_pkg::REQ_ALLOC) ? S_FSCAN : S_RSCAN;
        end
      end
      S_FSCAN: begin
        if (sts.scan_end) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_status = ffra_pkg::ST_NOFIT;
          state_next = S_OUT;
        end else if (sts.alloc_fit) begin
          state_next = S_USCAN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_USCAN: begin
        if (sts.used_hit) begin
          state_next = S_AAPPLY;
        end else if (sts.used_end) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_status = ffra_pkg::ST_FULL;
          state_next = S_OUT;
        end else begin
          cmd.uscan_step = 1'b1;
        end
      end
      S_AAPPLY: begin
        cmd.alloc_apply = 1'b1;
        st_hold_next = ffra_pkg::ST_OK;
        state_next = sts.exact ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) state_next = S_DONE;
      end
      S_RSCAN: begin
        if (sts.used_hit) begin
          state_next = S_FFIND;
        end else if (sts.used_end) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_status = ffra_pkg::ST_NOTALLOC;
          state_next = S_OUT;
        end else begin
          cmd.uscan_step = 1'b1;
        end
      end
      S_FFIND: begin
        if (sts.scan_end) begin
          // append at the end
          if (sts.free_full) begin
            cmd.set_rsp = 1'b1;
            cmd.rsp_status = ffra_pkg::ST_FULL;
            state_next = S_OUT;
          end else begin
            cmd.release_used = 1'b1;
            cmd.ins_open = 1'b1;
            st_hold_next = ffra_pkg::ST_OK;
            state_next = S_SHIFT;
          end
        end else if (sts.free_after) begin
          state_next = S_FDECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FDECIDE: begin
        st_hold_next = ffra_pkg::ST_OK;
        if (sts.adj_prev) begin
          cmd.release_used = 1'b1;
          cmd.merge_prev = 1'b1;
          state_next = S_FOLD;
        end else if (sts.adj_next) begin
          cmd.release_used = 1'b1;
          cmd.merge_next = 1'b1;
          state_next = S_DONE;
        end else if (sts.free_full) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_status = ffra_pkg::ST_FULL;
          state_next = S_OUT;
        end else begin
          cmd.release_used = 1'b1;
          cmd.ins_open = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_FOLD: begin
        if (sts.fold_ok) begin
          cmd.merge_fold = 1'b1;
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.set_rsp = 1'b1;
        cmd.rsp_status = st_hold;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
